[hw/rtl/crcfrc_pkg.sv]
// Shared types and constants for the framed record checker.
// Holds the status codes, the result struct and the byte-wide CRC-32 update.
// No dependencies.
package crcfrc_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned COUNT_W     = 4;

   localparam logic [WORD_W-1:0]      CRC_POLY       = 32'hEDB8_8320;
   localparam logic [WORD_W-1:0]      CRC_PRESET     = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0]      MAGIC_RESET    = 32'h5446_4152;
   localparam logic [WORD_W-1:0]      VERSION_RESET  = 32'h0000_0001;
   localparam logic [COUNT_W-1:0]     MIN_RECORD_LEN = 4'd12;
   localparam logic [COUNT_W-1:0]     MAGIC_END      = 4'd4;
   localparam logic [COUNT_W-1:0]     VERSION_END    = 4'd8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION    = 8'd1;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_SHORT,
      STATUS_BAD_MAGIC,
      STATUS_BAD_VERSION,
      STATUS_BAD_CRC
   } status_type;

   typedef struct packed {
      logic       frame_ok;
      status_type status;
   } result_type;

   // One reflected CRC-32 byte update, eight bit steps.
   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                  input logic [DATA_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {{(WORD_W-DATA_W){1'b0}}, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[hw/rtl/crcfrc_engine.sv]
// Per-record check state: running CRC, tail window, byte count, header flags.
// Produces the record status on the final byte. Depends on crcfrc_pkg.
module crcfrc_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   input  logic [31:0]               expected_magic,
   input  logic [31:0]               expected_version,
   output crcfrc_pkg::result_type    result
);
   import crcfrc_pkg::*;

   logic [WORD_W-1:0]  crc_ff, crc_in;
   logic [WORD_W-1:0]  tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               magic_bad_ff, magic_bad_in;
   logic               version_bad_ff, version_bad_in;

   logic [DATA_W-1:0]  magic_want;
   logic [DATA_W-1:0]  version_want;
   status_type         status;

   assign magic_want   = expected_magic[{count_ff[1:0], 3'b000} +: DATA_W];
   assign version_want = expected_version[{count_ff[1:0], 3'b000} +: DATA_W];

   always_comb begin
      magic_bad_in   = magic_bad_ff;
      version_bad_in = version_bad_ff;
      if (count_ff < MAGIC_END) begin
         magic_bad_in = magic_bad_ff | (data_byte != magic_want);
      end else if (count_ff < VERSION_END) begin
         version_bad_in = version_bad_ff | (data_byte != version_want);
      end
      crc_in   = (count_ff >= MAGIC_END) ? crc_byte(crc_ff, tail_ff[DATA_W-1:0]) : crc_ff;
      tail_in  = {data_byte, tail_ff[WORD_W-1:DATA_W]};
      count_in = (count_ff < MIN_RECORD_LEN) ? count_ff + 4'd1 : count_ff;

      if (count_in < MIN_RECORD_LEN) begin
         status = STATUS_SHORT;
      end else if (magic_bad_in) begin
         status = STATUS_BAD_MAGIC;
      end else if (version_bad_in) begin
         status = STATUS_BAD_VERSION;
      end else if ((crc_in ^ CRC_PRESET) != tail_in) begin
         status = STATUS_BAD_CRC;
      end else begin
         status = STATUS_OK;
      end
      result.status   = status;
      result.frame_ok = (status == STATUS_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff         <= CRC_PRESET;
         tail_ff        <= '0;
         count_ff       <= '0;
         magic_bad_ff   <= 1'b0;
         version_bad_ff <= 1'b0;
      end else if (step) begin
         if (last_byte) begin
            crc_ff         <= CRC_PRESET;
            tail_ff        <= '0;
            count_ff       <= '0;
            magic_bad_ff   <= 1'b0;
            version_bad_ff <= 1'b0;
         end else begin
            crc_ff         <= crc_in;
            tail_ff        <= tail_in;
            count_ff       <= count_in;
            magic_bad_ff   <= magic_bad_in;
            version_bad_ff <= version_bad_in;
         end
      end
   end

endmodule

[hw/rtl/crc_framed_record_checker.sv]
// Framed record checker: length, magic, version and trailing CRC-32 per record.
// Throughput is one byte per cycle, the CRC taking one unrolled byte step a cycle,
// while rsp keeps up; the final byte's status is registered after the input register.
// A stalled rsp side holds the status and stops input only at the next final byte.
// Synchronous reset clears the record state and loads the register defaults.
module crc_framed_record_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] frame_ok, [3:1] status, [7:4] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);
   import crcfrc_pkg::*;

   logic [WORD_W-1:0] magic_ff;
   logic [WORD_W-1:0] version_ff;

   logic              in_valid_ff;
   logic [DATA_W-1:0] in_byte_ff;
   logic              in_last_ff;

   logic              out_valid_ff;
   result_type        out_result_ff;

   logic              step;
   result_type        result;

   assign csr_ready  = 1'b1;
   assign step       = in_valid_ff & (~in_last_ff | ~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | step;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= MAGIC_RESET;
         version_ff <= VERSION_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_MAGIC) begin
            magic_ff <= csr_data;
         end else if (csr_index == CSR_VERSION) begin
            version_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready & req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   crcfrc_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .data_byte        (in_byte_ff),
      .last_byte        (in_last_ff),
      .expected_magic   (magic_ff),
      .expected_version (version_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step & in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (step & in_last_ff) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.status, out_result_ff.frame_ok};

endmodule
